@@ rtl/rmst_pkg.sv @@
// Package for the range minimum segment tree.
// Field widths, payload structs, operation codes and constants.
// No dependencies.
`timescale 1ns / 1ps

package rmst_pkg;

  localparam int VAL_W      = 64;
  localparam int SIZE_W     = 11;
  localparam int POS_W      = 10;
  localparam int END_W      = 11;
  localparam int NEWV_W     = 32;
  localparam int LEAVES_DEF = 1024;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic signed [VAL_W-1:0] LARGEST = 64'sh7FFF_FFFF_FFFF_FFFF;

  localparam logic FUNC_SET   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [POS_W-1:0]         position;
    logic [END_W-1:0]         range_end;
    logic signed [NEWV_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] min_value;
    logic                    index_error;
  } out_item_t;

endpackage

@@ rtl/rmst_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rmst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/range_minimum_segment_tree.sv @@
// Range minimum segment tree, top level: sequencer, shared min unit, node RAM.
// Depends on rmst_pkg and rmst_ram.
`timescale 1ns / 1ps

// Keeps the minima of LEAVES signed leaves in a bottom-up tree of 2*LEAVES
// nodes held in one RAM. After reset the block sweeps the RAM with the
// largest value, one node a cycle, and stalls input meanwhile;
// configuration writes are taken at any time. A set writes the leaf, then
// for each ancestor in turn the registered sibling read meets the one
// comparator and the parent is written. A set at or beyond the bound is
// dropped. A query climbs the tree a level at a time (a full range climbs
// 11 levels at the default size); the single RAM read port fetches the
// left and right border nodes on separate cycles. Out-of-bounds and empty
// queries go straight to the output register.
// The block works on one item at a time; a result waits in the output
// register while the next item is accepted.
module range_minimum_segment_tree
  import rmst_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int NW = $clog2(2 * LEAVES);
  localparam int RW = NW + 1;
  localparam int XW = (RW > SIZE_W) ? RW : SIZE_W;
  localparam int DEPTH = 2 * LEAVES;

  localparam logic [XW-1:0] LEAVES_X = XW'(LEAVES);
  localparam logic [NW-1:0] LAST_NODE = NW'(DEPTH - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LEAF  = 3'd2;
  localparam logic [2:0] S_UP    = 3'd3;
  localparam logic [2:0] S_QL    = 3'd4;
  localparam logic [2:0] S_QR    = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [NW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [SIZE_W-1:0]       used_size_r;
  logic [RW-1:0]           l_r, l_nxt;
  logic [RW-1:0]           r_r, r_nxt;
  logic signed [VAL_W-1:0] acc_r, acc_nxt;
  logic                    err_r, err_nxt;
  logic                    pend_r, pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic                    ram_we, ram_re;
  logic [NW-1:0]           ram_waddr, ram_raddr;
  logic [VAL_W-1:0]        ram_wdata, ram_rdata;
  logic signed [VAL_W-1:0] rd_val, min_val;

  logic                    in_acc;
  logic [XW-1:0]           bound, pos_x, end_x, used_x;
  logic [XW-1:0]           pos_node_x, end_node_x;
  logic [RW-1:0]           parent, sibling, r_dec;

  rmst_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared min unit: accumulator against the word just read
  assign rd_val  = $signed(ram_rdata);
  assign min_val = (rd_val < acc_r) ? rd_val : acc_r;

  assign used_x     = XW'(used_size_r);
  assign bound      = (used_x < LEAVES_X) ? used_x : LEAVES_X;
  assign pos_x      = XW'(in_data.position);
  assign end_x      = XW'(in_data.range_end);
  assign pos_node_x = pos_x + LEAVES_X;
  assign end_node_x = end_x + LEAVES_X;
  assign parent     = l_r >> 1;
  assign sibling    = parent ^ RW'(1);
  assign r_dec      = r_r - RW'(1);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = l_r[NW-1:0];
    ram_wdata     = acc_r;
    ram_re        = 1'b0;
    ram_raddr     = l_r[NW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = LARGEST;
        clr_cnt_nxt = clr_cnt_r + NW'(1);
        if (clr_cnt_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.func == FUNC_SET) begin
            if (pos_x < bound) begin
              acc_nxt   = VAL_W'(in_data.new_value);
              l_nxt     = pos_node_x[RW-1:0];
              state_nxt = S_LEAF;
            end
          end else begin
            acc_nxt  = LARGEST;
            err_nxt  = 1'b0;
            pend_nxt = 1'b0;
            l_nxt    = pos_node_x[RW-1:0];
            r_nxt    = end_node_x[RW-1:0];
            if (end_x > bound) begin
              err_nxt   = 1'b1;
              state_nxt = S_EMIT;
            end else if (pos_x >= end_x) begin
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_QL;
            end
          end
        end
      end
      S_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = l_r[NW-1:0];
        ram_re    = 1'b1;
        ram_raddr = l_r[NW-1:0] ^ NW'(1);
        state_nxt = S_UP;
      end
      S_UP: begin
        // sibling word is in; write the parent and fetch the next sibling
        ram_we    = 1'b1;
        ram_waddr = parent[NW-1:0];
        ram_wdata = min_val;
        acc_nxt   = min_val;
        l_nxt     = parent;
        if (parent == RW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = sibling[NW-1:0];
        end
      end
      S_QL: begin
        if (pend_r) begin
          acc_nxt = min_val;
        end
        pend_nxt = 1'b0;
        if (l_r >= r_r) begin
          state_nxt = S_EMIT;
        end else begin
          if (l_r[0]) begin
            ram_re    = 1'b1;
            ram_raddr = l_r[NW-1:0];
            pend_nxt  = 1'b1;
            l_nxt     = l_r + RW'(1);
          end
          state_nxt = S_QR;
        end
      end
      S_QR: begin
        if (pend_r) begin
          acc_nxt = min_val;
        end
        pend_nxt = r_r[0];
        if (r_r[0]) begin
          ram_re    = 1'b1;
          ram_raddr = r_dec[NW-1:0];
        end
        // (r-1)>>1 equals r>>1 when r is odd
        l_nxt     = l_r >> 1;
        r_nxt     = r_r >> 1;
        state_nxt = S_QL;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.min_value = acc_r;
          out_data_nxt.index_error = err_r;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      used_size_r <= SIZE_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        used_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/rmst_checker.sv @@
// Port-level checker for the range minimum segment tree, bound to the top level.
// Depends on rmst_pkg.
`timescale 1ns / 1ps

module rmst_checker
  import rmst_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input in_item_t          in_data,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_data
);

  // a held result keeps its value until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a bounds error always reports the largest value
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |-> out_data.min_value == LARGEST)
    else $error("index error with a value other than the largest");

  // an accepted query is always followed by a stalled input
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.func == FUNC_QUERY |=> in_stall)
    else $error("input taken straight after a query");

  // the clearing sweep holds off input after reset
  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not stalled after reset");

endmodule

bind range_minimum_segment_tree rmst_checker u_rmst_checker (.*);
